FILE: rtl/core/kway_merge_with_group_index_macros.svh
// Assertion macros shared by the merge block's modules.
`ifndef KWAY_MERGE_WITH_GROUP_INDEX_MACROS_SVH
`define KWAY_MERGE_WITH_GROUP_INDEX_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define KWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define KWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/core/kwm_pkg.sv
// Package with the shared constants, codes and types of the merge block.
package kwm_pkg;

  localparam int LANES = 16;
  localparam int NLN = (LANES < 16) ? LANES : 16;
  localparam int LW = $clog2(NLN);
  localparam int TREE = 1 << LW;
  localparam int CW = $clog2(LW + 1);
  localparam int LCW = 5;
  localparam int KW = 64;
  localparam int LENW = 31;
  localparam int OW = 64;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = 2;

  localparam logic [LCW-1:0] NLN_C = LCW'(NLN);

  typedef logic [1:0] lst_t;
  localparam lst_t ST_AWAIT = 2'd0;
  localparam lst_t ST_HOLD = 2'd1;
  localparam lst_t ST_END = 2'd2;

  localparam logic [1:0] KIND_REC = 2'd0;
  localparam logic [1:0] KIND_GRP = 2'd1;
  localparam logic [1:0] KIND_FIN = 2'd2;

  localparam logic REG_ACTIVE_LANES = 1'b0;
  localparam logic REG_INDEX_EN = 1'b1;

  typedef struct packed {
    logic [KW-1:0]   key;
    logic [LENW-1:0] first_len;
    logic [LENW-1:0] second_len;
  } head_t;

  typedef struct packed {
    logic valid;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic          take;
    logic          rel;
    logic          rec;
    logic [LW-1:0] lane;
  } fb_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [3:0]    from_lane;
    logic [KW-1:0] key;
    logic [OW-1:0] start_first;
    logic [OW-1:0] start_second;
    logic [OW-1:0] size_first;
    logic [OW-1:0] size_second;
    logic          last;
  } res_t;

endpackage

FILE: rtl/core/kwm_ofifo.sv
// Result queue between the pick engine and the result ports.
`include "kway_merge_with_group_index_macros.svh"

module kwm_ofifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  kwm_pkg::res_t din,
  output logic          wr_full,
  input  logic          rd_en,
  output logic          rd_empty,
  output kwm_pkg::res_t dout
);
  import kwm_pkg::*;

  res_t             mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign wr_full = (cnt_r == (OQ_AW+1)'(OQ_DEPTH));
  assign rd_empty = (cnt_r == '0);
  assign do_wr = wr_en && !wr_full;
  assign do_rd = rd_en && !rd_empty;
  assign dout = mem_r[rp_r];

  always_comb begin
    wp_nxt = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= din;
    end
  end

  `KWM_ASSERT(a_oq_count, cnt_r <= (OQ_AW+1)'(OQ_DEPTH), "result queue count out of range")

endmodule

FILE: rtl/core/kwm_front.sv
// Front end: takes header beats, keeps lane heads and status, posts picks.
`include "kway_merge_with_group_index_macros.svh"

module kwm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [3:0]                  in_lane,
  input  logic [kwm_pkg::KW-1:0]      in_key,
  input  logic [kwm_pkg::LENW-1:0]    in_first_len,
  input  logic [kwm_pkg::LENW-1:0]    in_second_len,
  input  logic                        in_lane_ended,
  input  logic [kwm_pkg::LCW-1:0]     lane_cnt,
  output kwm_pkg::cmd_t               cmd_o,
  input  kwm_pkg::fb_t                fb_i,
  output kwm_pkg::head_t              head_o [kwm_pkg::NLN],
  output kwm_pkg::lst_t               status_o [kwm_pkg::NLN]
);
  import kwm_pkg::*;

  head_t         head_r [NLN];
  lst_t          status_r [NLN];
  lst_t          status_nxt [NLN];
  cmd_t          cmd_r, cmd_nxt;
  logic          pending_r, pending_nxt;
  logic          done_r, done_nxt;
  logic          accept, hdr_ok, ended, any_wait, any_hold, post;
  logic [LW-1:0] lidx;

  assign full = pending_r;
  assign accept = push && !full;
  assign lidx = in_lane[LW-1:0];
  assign ended = in_lane_ended || (in_key == '1);
  assign hdr_ok = accept && !done_r && ({1'b0, in_lane} < lane_cnt) &&
                  (status_r[lidx] == ST_AWAIT);

  always_comb begin
    any_wait = 1'b0;
    any_hold = 1'b0;
    for (int i = 0; i < NLN; i++) begin
      status_nxt[i] = status_r[i];
      if (hdr_ok && (lidx == LW'(i))) begin
        status_nxt[i] = ended ? ST_END : ST_HOLD;
      end
      if (fb_i.rel && fb_i.rec && (fb_i.lane == LW'(i))) begin
        status_nxt[i] = ST_AWAIT;
      end
      if (LCW'(i) < lane_cnt) begin
        if (status_nxt[i] == ST_AWAIT) begin
          any_wait = 1'b1;
        end
        if (status_nxt[i] == ST_HOLD) begin
          any_hold = 1'b1;
        end
      end
    end
    post = hdr_ok && !any_wait;

    cmd_nxt = cmd_r;
    if (post) begin
      cmd_nxt.valid = 1'b1;
      cmd_nxt.fin = !any_hold;
    end else if (fb_i.take) begin
      cmd_nxt.valid = 1'b0;
    end

    pending_nxt = pending_r;
    if (post) begin
      pending_nxt = 1'b1;
    end else if (fb_i.rel) begin
      pending_nxt = 1'b0;
    end

    done_nxt = done_r || (post && !any_hold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLN; i++) begin
        status_r[i] <= ST_AWAIT;
      end
      cmd_r <= '0;
      pending_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      status_r <= status_nxt;
      cmd_r <= cmd_nxt;
      pending_r <= pending_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_ok && !ended) begin
      head_r[lidx] <= '{key: in_key, first_len: in_first_len, second_len: in_second_len};
    end
  end

  assign cmd_o = cmd_r;
  assign head_o = head_r;
  assign status_o = status_r;

  `KWM_ASSERT_IMP(a_cmd_pending, cmd_r.valid, pending_r, "pick posted without pending flag")

endmodule

FILE: rtl/core/kwm_back.sv
// Back end: finds the smallest head, tracks groups and writes result beats.
`include "kway_merge_with_group_index_macros.svh"

module kwm_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kwm_pkg::cmd_t           cmd_i,
  output kwm_pkg::fb_t            fb_o,
  input  kwm_pkg::head_t          head_i [kwm_pkg::NLN],
  input  kwm_pkg::lst_t           status_i [kwm_pkg::NLN],
  input  logic [kwm_pkg::LCW-1:0] lane_cnt,
  input  logic                    index_en,
  input  logic                    oq_full,
  output logic                    oq_push,
  output kwm_pkg::res_t           oq_data
);
  import kwm_pkg::*;

  typedef struct packed {
    logic       valid;
    logic [3:0] lane;
    head_t      hd;
  } cand_t;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED = 3'd1;
  localparam logic [2:0] S_GRP = 3'd2;
  localparam logic [2:0] S_REC = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  function automatic cand_t cand_min(input cand_t a, input cand_t b);
    cand_t r;
    if (a.valid && (!b.valid || (a.hd.key <= b.hd.key))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

  logic [2:0]    state_r, state_nxt;
  cand_t         cand_r [TREE];
  cand_t         cand_nxt [TREE];
  cand_t         load_c [TREE];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] prev_key_r, prev_key_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [OW-1:0] tot1_r, tot1_nxt, tot2_r, tot2_nxt;
  logic [OW-1:0] gs1_r, gs1_nxt, gs2_r, gs2_nxt;
  cand_t         win;
  logic          chg;

  for (genvar g = 0; g < TREE; g++) begin : g_load
    if (g < NLN) begin : g_lane
      assign load_c[g].valid = (LCW'(g) < lane_cnt) && (status_i[g] == ST_HOLD);
      assign load_c[g].lane = 4'(g);
      assign load_c[g].hd = head_i[g];
    end else begin : g_pad
      assign load_c[g] = '0;
    end
  end

  assign win = cand_r[0];
  assign chg = have_prev_r && (win.hd.key != prev_key_r);

  always_comb begin
    state_nxt = state_r;
    cand_nxt = cand_r;
    cnt_nxt = cnt_r;
    prev_key_nxt = prev_key_r;
    have_prev_nxt = have_prev_r;
    tot1_nxt = tot1_r;
    tot2_nxt = tot2_r;
    gs1_nxt = gs1_r;
    gs2_nxt = gs2_r;
    fb_o = '0;
    fb_o.lane = win.lane[LW-1:0];
    oq_push = 1'b0;
    oq_data = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_i.valid) begin
          fb_o.take = 1'b1;
          if (cmd_i.fin) begin
            state_nxt = S_FIN;
          end else begin
            cand_nxt = load_c;
            cnt_nxt = '0;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        for (int i = 0; i < TREE / 2; i++) begin
          cand_nxt[i] = cand_min(cand_r[2*i], cand_r[2*i+1]);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(LW - 1)) begin
          state_nxt = S_GRP;
        end
      end
      S_GRP: begin
        if (chg && index_en) begin
          oq_data.kind = KIND_GRP;
          oq_data.key = prev_key_r;
          oq_data.start_first = gs1_r;
          oq_data.start_second = gs2_r;
          oq_data.size_first = tot1_r - gs1_r;
          oq_data.size_second = tot2_r - gs2_r;
          if (!oq_full) begin
            oq_push = 1'b1;
            gs1_nxt = tot1_r;
            gs2_nxt = tot2_r;
            state_nxt = S_REC;
          end
        end else begin
          if (chg) begin
            gs1_nxt = tot1_r;
            gs2_nxt = tot2_r;
          end
          state_nxt = S_REC;
        end
      end
      S_REC: begin
        oq_data.kind = KIND_REC;
        oq_data.from_lane = win.lane;
        oq_data.key = win.hd.key;
        oq_data.start_first = tot1_r;
        oq_data.start_second = tot2_r;
        oq_data.size_first = OW'(win.hd.first_len);
        oq_data.size_second = OW'(win.hd.second_len);
        oq_data.last = 1'b1;
        if (!oq_full) begin
          oq_push = 1'b1;
          tot1_nxt = tot1_r + OW'(win.hd.first_len);
          tot2_nxt = tot2_r + OW'(win.hd.second_len);
          prev_key_nxt = win.hd.key;
          have_prev_nxt = 1'b1;
          fb_o.rel = 1'b1;
          fb_o.rec = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        oq_data.kind = KIND_FIN;
        oq_data.key = prev_key_r;
        oq_data.start_first = gs1_r;
        oq_data.start_second = gs2_r;
        oq_data.size_first = tot1_r - gs1_r;
        oq_data.size_second = tot2_r - gs2_r;
        oq_data.last = 1'b1;
        if (!oq_full) begin
          oq_push = 1'b1;
          fb_o.rel = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      prev_key_r <= '1;
      have_prev_r <= 1'b0;
      tot1_r <= '0;
      tot2_r <= '0;
      gs1_r <= '0;
      gs2_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      prev_key_r <= prev_key_nxt;
      have_prev_r <= have_prev_nxt;
      tot1_r <= tot1_nxt;
      tot2_r <= tot2_nxt;
      gs1_r <= gs1_nxt;
      gs2_r <= gs2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  `KWM_ASSERT_IMP(a_win_valid, state_r == S_GRP, cand_r[0].valid, "pick found no held lane")
  `KWM_ASSERT_IMP(a_push_room, oq_push, !oq_full, "result written into a full queue")

endmodule

FILE: rtl/core/kway_merge_with_group_index.sv
// Top level of the k-way merge with per-key group index.
//
// Each header beat on the input side fills one lane. A beat that leaves some
// active lane still waiting is taken without raising full. A beat that
// completes the set starts a pick, and full stays high while the pick runs.
// The pick is registered and handed to the back end, which then reduces the
// lane heads level by level through the shared pairwise compare stage. A
// group step follows, whether or not it writes a group index beat, and then
// a record step writes the record beat, after which full drops and the next
// header beat can be taken. A pick that closes the merge writes the final
// beat and then releases full. The four-beat result queue sits between the
// pick and the result ports. Results are read from it while new header beats
// are taken, and a full result queue holds the pick until there is room.
module kway_merge_with_group_index (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [3:0]               in_lane,
  input  logic [63:0]              in_key,
  input  logic [30:0]              in_first_len,
  input  logic [30:0]              in_second_len,
  input  logic                     in_lane_ended,
  input  logic                     pop,
  output logic                     empty,
  output logic [1:0]               out_kind,
  output logic [3:0]               out_from_lane,
  output logic [63:0]              out_key,
  output logic [63:0]              out_start_first,
  output logic [63:0]              out_start_second,
  output logic [63:0]              out_size_first,
  output logic [63:0]              out_size_second,
  output logic                     out_last,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [kwm_pkg::LCW-1:0]  cfg_wdata
);
  import kwm_pkg::*;

  logic [LCW-1:0] act_r;
  logic           idx_en_r;
  logic [LCW-1:0] lane_cnt;
  cmd_t           cmd;
  fb_t            fb;
  head_t          heads [NLN];
  lst_t           status [NLN];
  logic           oq_full, oq_push;
  res_t           oq_din, oq_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= LCW'(16);
      idx_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACTIVE_LANES: act_r <= cfg_wdata;
        REG_INDEX_EN: idx_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (act_r == '0) begin
      lane_cnt = LCW'(1);
    end else if (act_r > NLN_C) begin
      lane_cnt = NLN_C;
    end else begin
      lane_cnt = act_r;
    end
  end

  kwm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_lane       (in_lane),
    .in_key        (in_key),
    .in_first_len  (in_first_len),
    .in_second_len (in_second_len),
    .in_lane_ended (in_lane_ended),
    .lane_cnt      (lane_cnt),
    .cmd_o         (cmd),
    .fb_i          (fb),
    .head_o        (heads),
    .status_o      (status)
  );

  kwm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_i    (cmd),
    .fb_o     (fb),
    .head_i   (heads),
    .status_i (status),
    .lane_cnt (lane_cnt),
    .index_en (idx_en_r),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_din)
  );

  kwm_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (oq_push),
    .din      (oq_din),
    .wr_full  (oq_full),
    .rd_en    (pop),
    .rd_empty (empty),
    .dout     (oq_dout)
  );

  assign out_kind = oq_dout.kind;
  assign out_from_lane = oq_dout.from_lane;
  assign out_key = oq_dout.key;
  assign out_start_first = oq_dout.start_first;
  assign out_start_second = oq_dout.start_second;
  assign out_size_first = oq_dout.size_first;
  assign out_size_second = oq_dout.size_second;
  assign out_last = oq_dout.last;

endmodule
